// File: rtl/lgr_pkg.sv
// ----------------------------------------------------------------------------
// lgr_pkg
// shared types and constants of the log grid linear resampler
// ----------------------------------------------------------------------------
package lgr_pkg;

    localparam int MAX_RUN    = 64;
    localparam int RUN_W      = $clog2(MAX_RUN + 1);
    localparam int DIV_STEPS  = 32;
    localparam int DIV_W      = $clog2(DIV_STEPS);
    localparam int RATIO_FRAC = 30;

    localparam logic [31:0] GRID_START_RST = 32'h0001_0000;
    localparam logic [31:0] GRID_END_RST   = 32'hFFFF_FFFF;
    localparam logic [31:0] GRID_RATIO_RST = 32'd1181116006;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_END    = 2'd1;
    localparam logic [1:0] MODE_CONT   = 2'd2;

    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_END   = 2'd1;
    localparam logic [1:0] CFG_RATIO = 2'd2;

    typedef enum logic [2:0] {
        PH_AWAIT,
        PH_LEADIN,
        PH_READY,
        PH_SEGMENT,
        PH_FLUSH,
        PH_FIN
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_PROD,
        S_NUM,
        S_DIV,
        S_VALUE,
        S_ADV,
        S_DECIDE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic   ld_lower;
        logic   ld_upper;
        logic   set_phase;
        t_phase phase_val;
        logic   mark_fin;
        logic   finalize;
        logic   prod;
        logic   num;
        logic   div_step;
        logic   value;
        logic   adv;
        logic   out_load;
        logic   out_last;
        logic   out_more;
        logic   out_fin;
    } t_cmd;

    typedef struct packed {
        t_phase phase;
        logic   due;
        logic   past_end;
    } t_status;

endpackage

// File: rtl/log_grid_linear_resampler_unit.sv
// ----------------------------------------------------------------------------
// log_grid_linear_resampler_unit
// resamples x-y samples onto a geometric grid with linear interpolation
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  -------   -------------------------  ------------------------------------
//  input     i_valid / o_ready          i_mode, i_sample_x, i_sample_y
//  result    o_valid / i_ready          o_grid_x, o_value, o_last, o_more,
//                                       o_finished
//  config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  a request is decoded and started, then produces grid points (up to 64);
//  the result side can stall the delivery of each point
//  each point costs two multiplies, a 32-step restoring divide and one grid step
//  reset is synchronous and active low; config registers return to defaults
//  one request is worked on at a time; a new request is taken only when the
//  last result of the previous one has been delivered
//
module log_grid_linear_resampler_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input requests
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic [31:0]        i_sample_x,
    input  logic signed [31:0] i_sample_y,
    // results
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_grid_x,
    output logic signed [31:0] o_value,
    output logic               o_last,
    output logic               o_more,
    output logic               o_finished,
    // config writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    lgr_pkg::t_cmd    w_cmd;
    lgr_pkg::t_status w_status;

    // config is always writable
    assign o_cfg_ready = 1'b1;

    lgr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_mode      (i_mode),
        .i_out_ready (i_ready),
        .i_status    (w_status),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    lgr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_sample_x  (i_sample_x),
        .i_sample_y  (i_sample_y),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (w_status),
        .o_grid_x    (o_grid_x),
        .o_value     (o_value),
        .o_last      (o_last),
        .o_more      (o_more),
        .o_finished  (o_finished)
    );

endmodule

// File: rtl/lgr_ctrl.sv
// ----------------------------------------------------------------------------
// lgr_ctrl
// sequencer: decodes requests, steps the datapath through each grid point
// ----------------------------------------------------------------------------
module lgr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_mode,
    input  logic             i_out_ready,
    input  lgr_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output lgr_pkg::t_cmd    o_cmd
);

    lgr_pkg::t_state                 r_state, n_state;
    logic [lgr_pkg::RUN_W-1:0]       r_run, n_run;
    logic [lgr_pkg::DIV_W-1:0]       r_div, n_div;
    logic                            r_cont, n_cont;

    logic w_go, w_cont, w_pending, w_fin;

    assign w_fin = (i_status.phase == lgr_pkg::PH_FIN);

    always_comb begin
        w_go = 1'b0;
        if (!w_fin) begin
            case (i_mode)
                lgr_pkg::MODE_SAMPLE,
                lgr_pkg::MODE_END: w_go = (i_status.phase == lgr_pkg::PH_AWAIT) ||
                                          (i_status.phase == lgr_pkg::PH_READY);
                lgr_pkg::MODE_CONT: w_go = (i_status.phase == lgr_pkg::PH_LEADIN) ||
                                           (i_status.phase == lgr_pkg::PH_SEGMENT) ||
                                           (i_status.phase == lgr_pkg::PH_FLUSH);
                default: w_go = 1'b0;
            endcase
        end
    end

    assign w_pending = !w_fin && i_status.due;
    assign w_cont    = w_pending && (r_run < lgr_pkg::RUN_W'(lgr_pkg::MAX_RUN));

    // next state
    always_comb begin
        n_state = r_state;
        n_run   = r_run;
        n_div   = r_div;
        n_cont  = r_cont;
        case (r_state)
            lgr_pkg::S_IDLE: begin
                n_run = '0;
                if (i_in_valid && w_go) n_state = lgr_pkg::S_START;
            end
            lgr_pkg::S_START: begin
                if (i_status.past_end || !i_status.due) n_state = lgr_pkg::S_IDLE;
                else n_state = lgr_pkg::S_PROD;
            end
            lgr_pkg::S_PROD: n_state = lgr_pkg::S_NUM;
            lgr_pkg::S_NUM: begin
                n_div   = '0;
                n_state = lgr_pkg::S_DIV;
            end
            lgr_pkg::S_DIV: begin
                n_div = r_div + 1'b1;
                if (r_div == lgr_pkg::DIV_W'(lgr_pkg::DIV_STEPS - 1))
                    n_state = lgr_pkg::S_VALUE;
            end
            lgr_pkg::S_VALUE: n_state = lgr_pkg::S_ADV;
            lgr_pkg::S_ADV: begin
                n_run   = r_run + 1'b1;
                n_state = lgr_pkg::S_DECIDE;
            end
            lgr_pkg::S_DECIDE: begin
                n_cont  = w_cont;
                n_state = lgr_pkg::S_EMIT;
            end
            lgr_pkg::S_EMIT: begin
                if (i_out_ready) n_state = r_cont ? lgr_pkg::S_PROD : lgr_pkg::S_IDLE;
            end
            default: n_state = lgr_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = (r_state == lgr_pkg::S_IDLE);
        o_out_valid = (r_state == lgr_pkg::S_EMIT);
        case (r_state)
            lgr_pkg::S_IDLE: begin
                if (i_in_valid && w_go) begin
                    case (i_mode)
                        lgr_pkg::MODE_SAMPLE: begin
                            o_cmd.set_phase = 1'b1;
                            if (i_status.phase == lgr_pkg::PH_AWAIT) begin
                                o_cmd.ld_lower  = 1'b1;
                                o_cmd.phase_val = lgr_pkg::PH_LEADIN;
                            end else begin
                                o_cmd.ld_upper  = 1'b1;
                                o_cmd.phase_val = lgr_pkg::PH_SEGMENT;
                            end
                        end
                        lgr_pkg::MODE_END: begin
                            o_cmd.set_phase = 1'b1;
                            o_cmd.phase_val = lgr_pkg::PH_FLUSH;
                        end
                        default: o_cmd.set_phase = 1'b0;
                    endcase
                end
            end
            lgr_pkg::S_START: begin
                if (i_status.past_end) o_cmd.mark_fin = 1'b1;
                else if (!i_status.due) o_cmd.finalize = 1'b1;
            end
            lgr_pkg::S_PROD:  o_cmd.prod     = 1'b1;
            lgr_pkg::S_NUM:   o_cmd.num      = 1'b1;
            lgr_pkg::S_DIV:   o_cmd.div_step = 1'b1;
            lgr_pkg::S_VALUE: o_cmd.value    = 1'b1;
            lgr_pkg::S_ADV:   o_cmd.adv      = 1'b1;
            lgr_pkg::S_DECIDE: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_last = !w_cont;
                o_cmd.out_more = !w_cont && w_pending;
                o_cmd.out_fin  = !w_cont && w_fin;
                o_cmd.finalize = !w_pending && !w_fin;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lgr_pkg::S_IDLE;
            r_run   <= '0;
            r_div   <= '0;
            r_cont  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
            r_div   <= n_div;
            r_cont  <= n_cont;
        end
    end

endmodule

// File: rtl/lgr_datapath.sv
// ----------------------------------------------------------------------------
// lgr_datapath
// segment and grid state, shared multiplier, restoring divider, result register
// ----------------------------------------------------------------------------
module lgr_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lgr_pkg::t_cmd       i_cmd,
    input  logic [31:0]         i_sample_x,
    input  logic signed [31:0]  i_sample_y,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output lgr_pkg::t_status    o_status,
    output logic [31:0]         o_grid_x,
    output logic signed [31:0]  o_value,
    output logic                o_last,
    output logic                o_more,
    output logic                o_finished
);

    logic [31:0]        r_grid_end, r_grid_ratio;
    logic [31:0]        r_lower_x, r_upper_x, r_next_grid;
    logic signed [31:0] r_lower_y, r_upper_y;
    lgr_pkg::t_phase    r_phase;

    logic [63:0]        r_prod;
    logic [31:0]        r_dx, r_gx, r_rem, r_q;
    logic               r_dyneg, r_direct, r_zero;

    logic [31:0]        r_out_gx;
    logic signed [31:0] r_out_val;
    logic               r_out_last, r_out_more, r_out_fin;

    logic [31:0]        w_dx, w_dxp_raw, w_dxp, w_ady, w_ma, w_mb;
    logic signed [32:0] w_dy;
    logic [63:0]        w_mul, w_num;
    logic [32:0]        w_trial;
    logic               w_ge;
    logic [33:0]        w_nx;
    logic               w_direct;

    // segment geometry for the current grid point
    assign w_dx      = r_upper_x - r_lower_x;
    assign w_dxp_raw = r_next_grid - r_lower_x;
    assign w_dxp     = (w_dxp_raw > w_dx) ? w_dx : w_dxp_raw;
    assign w_dy      = 33'(r_upper_y) - 33'(r_lower_y);
    assign w_ady     = w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
    assign w_direct  = (r_upper_x <= r_lower_x) || (r_next_grid < r_lower_x);

    // one multiplier: |dy| * dxp, then grid * ratio
    assign w_ma  = i_cmd.prod ? w_ady : r_next_grid;
    assign w_mb  = i_cmd.prod ? w_dxp : r_grid_ratio;
    assign w_mul = 64'(w_ma) * 64'(w_mb);

    assign w_num   = r_prod + 64'(r_dx >> 1);
    assign w_trial = {r_rem, r_q[31]};
    assign w_ge    = w_trial >= {1'b0, r_dx};

    assign w_nx = 34'((r_prod + (64'd1 << (lgr_pkg::RATIO_FRAC - 1))) >> lgr_pkg::RATIO_FRAC);

    always_comb begin
        o_status.phase    = r_phase;
        o_status.past_end = r_next_grid > r_grid_end;
        case (r_phase)
            lgr_pkg::PH_LEADIN:  o_status.due = r_next_grid < r_lower_x;
            lgr_pkg::PH_SEGMENT: o_status.due = r_next_grid <= r_upper_x;
            lgr_pkg::PH_FLUSH:   o_status.due = 1'b1;
            default:             o_status.due = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_end   <= lgr_pkg::GRID_END_RST;
            r_grid_ratio <= lgr_pkg::GRID_RATIO_RST;
            r_lower_x    <= '0;
            r_upper_x    <= '0;
            r_lower_y    <= '0;
            r_upper_y    <= '0;
            r_next_grid  <= lgr_pkg::GRID_START_RST;
            r_phase      <= lgr_pkg::PH_AWAIT;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lgr_pkg::CFG_START: begin
                        if (r_phase == lgr_pkg::PH_AWAIT) r_next_grid <= i_cfg_data;
                    end
                    lgr_pkg::CFG_END:   r_grid_end   <= i_cfg_data;
                    lgr_pkg::CFG_RATIO: r_grid_ratio <= i_cfg_data;
                    default:            r_grid_end   <= r_grid_end;
                endcase
            end
            if (i_cmd.ld_lower) begin
                r_lower_x <= i_sample_x;
                r_lower_y <= i_sample_y;
            end
            if (i_cmd.ld_upper) begin
                r_upper_x <= i_sample_x;
                r_upper_y <= i_sample_y;
            end
            if (i_cmd.set_phase) r_phase <= i_cmd.phase_val;
            if (i_cmd.mark_fin) r_phase <= lgr_pkg::PH_FIN;
            if (i_cmd.finalize) begin
                if (r_phase == lgr_pkg::PH_SEGMENT) begin
                    r_lower_x <= r_upper_x;
                    r_lower_y <= r_upper_y;
                end
                r_phase <= lgr_pkg::PH_READY;
            end
            // grid step, saturating on overflow
            if (i_cmd.adv) begin
                if (w_nx > 34'(r_grid_end)) begin
                    r_next_grid <= (w_nx[33:32] != 2'b00) ? 32'hFFFF_FFFF : w_nx[31:0];
                    r_phase     <= lgr_pkg::PH_FIN;
                end else begin
                    r_next_grid <= w_nx[31:0];
                end
            end
        end
    end

    // arithmetic pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.prod || i_cmd.value) r_prod <= w_mul;
        if (i_cmd.prod) begin
            r_gx     <= r_next_grid;
            r_dx     <= w_dx;
            r_dyneg  <= w_dy[32];
            r_direct <= w_direct;
            r_zero   <= (r_phase != lgr_pkg::PH_SEGMENT);
        end
        if (i_cmd.num) begin
            r_rem <= w_num[63:32];
            r_q   <= w_num[31:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? 32'(w_trial - {1'b0, r_dx}) : w_trial[31:0];
            r_q   <= {r_q[30:0], w_ge};
        end
        if (i_cmd.value) begin
            if (r_zero)        r_out_val <= '0;
            else if (r_direct) r_out_val <= r_lower_y;
            else if (r_dyneg)  r_out_val <= r_lower_y - $signed(r_q);
            else               r_out_val <= r_lower_y + $signed(r_q);
        end
        if (i_cmd.out_load) begin
            r_out_gx   <= r_gx;
            r_out_last <= i_cmd.out_last;
            r_out_more <= i_cmd.out_more;
            r_out_fin  <= i_cmd.out_fin;
        end
    end

    assign o_grid_x   = r_out_gx;
    assign o_value    = r_out_val;
    assign o_last     = r_out_last;
    assign o_more     = r_out_more;
    assign o_finished = r_out_fin;

endmodule

// File: dv/log_grid_linear_resampler_unit_test.sv
// ----------------------------------------------------------------------------
// log_grid_linear_resampler_unit_test
// self-checking bench: drives sample, end and continue requests, predicts each
// grid point (geometric grid step, linear interpolation, run cut and finish)
// and compares every result field by field under idling and back pressure
// ----------------------------------------------------------------------------
module log_grid_linear_resampler_unit_test;

    // mode code the block must ignore
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [31:0] RATIO_MIN  = 32'h4000_0001;
    localparam logic [31:0] RATIO_MAX  = 32'hFFFF_FFFF;
    // roughly 1 + 1/256 per grid step
    localparam logic [31:0] RATIO_FINE = 32'h4040_0000;

    // cycles to let an item that yields no point finish before an idle action
    localparam int SETTLE     = 48;
    localparam int HOLD_LEN   = 1500;
    localparam int WDOG_LIMIT = 20000;
    localparam int PHASE_LEN  = 55;

    typedef struct packed {
        logic [31:0]        grid_x;
        logic signed [31:0] value;
        logic               last;
        logic               more;
        logic               fin;
    } t_grid_point;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_mode = lgr_pkg::MODE_SAMPLE;
    logic [31:0]        i_sample_x = '0;
    logic signed [31:0] i_sample_y = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [31:0]        o_grid_x;
    logic signed [31:0] o_value;
    logic               o_last;
    logic               o_more;
    logic               o_finished;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = lgr_pkg::CFG_START;
    logic [31:0]        i_cfg_data = '0;

    log_grid_linear_resampler_unit u_dut (.*);

    // grid points still owed by the block, oldest first
    t_grid_point expected_points[$];
    int          n_errors = 0;

    // idling knobs in percent: of requests sent after a gap, of receiver stall cycles
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;

    // receiver hold-off: the test bumps hold_seq, the receiver counts it out
    int          hold_seq = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    // resampler shadow: config, segment ends, next grid point, phase
    logic [31:0]        g_start = lgr_pkg::GRID_START_RST;
    logic [31:0]        g_end = lgr_pkg::GRID_END_RST;
    logic [31:0]        g_ratio = lgr_pkg::GRID_RATIO_RST;
    logic [31:0]        lo_x = '0;
    logic [31:0]        up_x = '0;
    logic signed [31:0] lo_y = '0;
    logic signed [31:0] up_y = '0;
    logic [31:0]        nxt_grid = lgr_pkg::GRID_START_RST;
    lgr_pkg::t_phase    ph = lgr_pkg::PH_AWAIT;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic logic grid_due();
        if (ph == lgr_pkg::PH_LEADIN)
            return nxt_grid < lo_x;
        if (ph == lgr_pkg::PH_SEGMENT)
            return nxt_grid <= up_x;
        return ph == lgr_pkg::PH_FLUSH;
    endfunction

    function automatic logic run_pending();
        return ph == lgr_pkg::PH_LEADIN || ph == lgr_pkg::PH_SEGMENT
            || ph == lgr_pkg::PH_FLUSH;
    endfunction

    // value on the segment at the current grid point, rounded half away
    function automatic logic signed [31:0] interp_value();
        logic [31:0]        dx;
        logic [31:0]        dxp;
        longint             dy;
        longint unsigned    ady;
        longint unsigned    mag;
        if (up_x <= lo_x || nxt_grid < lo_x)
            return lo_y;
        dx  = up_x - lo_x;
        dxp = nxt_grid - lo_x;
        if (dxp > dx)
            dxp = dx;
        dy  = longint'(up_y) - longint'(lo_y);
        ady = (dy < 0) ? longint'(-dy) : dy;
        mag = (ady * dxp + (dx >> 1)) / dx;
        return (dy < 0) ? lo_y - mag[31:0] : lo_y + mag[31:0];
    endfunction

    // multiply by the Q2.30 ratio, round half up, overflow passes the end
    function automatic void grid_step();
        logic [63:0] prod;
        logic [63:0] nx;
        prod = {32'd0, nxt_grid} * {32'd0, g_ratio} + 64'h2000_0000;
        nx   = prod >> lgr_pkg::RATIO_FRAC;
        if (nx > {32'd0, g_end}) begin
            nxt_grid = (nx > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nx[31:0];
            ph = lgr_pkg::PH_FIN;
        end else begin
            nxt_grid = nx[31:0];
        end
    endfunction

    function automatic void emit_run();
        int          n;
        logic        pend;
        t_grid_point pt;
        n = 0;
        if (nxt_grid > g_end)
            ph = lgr_pkg::PH_FIN;
        while (ph != lgr_pkg::PH_FIN && n < lgr_pkg::MAX_RUN && grid_due()) begin
            pt.grid_x = nxt_grid;
            pt.value  = (ph == lgr_pkg::PH_SEGMENT) ? interp_value() : '0;
            pt.last   = 1'b0;
            pt.more   = 1'b0;
            pt.fin    = 1'b0;
            expected_points.push_back(pt);
            n++;
            grid_step();
        end
        pend = ph != lgr_pkg::PH_FIN && grid_due();
        if (!pend && ph != lgr_pkg::PH_FIN) begin
            if (ph == lgr_pkg::PH_SEGMENT) begin
                lo_x = up_x;
                lo_y = up_y;
            end
            ph = lgr_pkg::PH_READY;
        end
        if (n > 0) begin
            expected_points[expected_points.size() - 1].last = 1'b1;
            expected_points[expected_points.size() - 1].more = pend;
            expected_points[expected_points.size() - 1].fin  = (ph == lgr_pkg::PH_FIN);
        end
    endfunction

    function automatic void resample_predict(logic [1:0] mode, logic [31:0] x,
                                             logic signed [31:0] y);
        if (ph == lgr_pkg::PH_FIN)
            return;
        case (mode)
            lgr_pkg::MODE_SAMPLE: begin
                if (ph == lgr_pkg::PH_AWAIT) begin
                    lo_x = x;
                    lo_y = y;
                    ph = lgr_pkg::PH_LEADIN;
                    emit_run();
                end else if (ph == lgr_pkg::PH_READY) begin
                    up_x = x;
                    up_y = y;
                    ph = lgr_pkg::PH_SEGMENT;
                    emit_run();
                end
            end
            lgr_pkg::MODE_END: begin
                if (ph == lgr_pkg::PH_AWAIT || ph == lgr_pkg::PH_READY) begin
                    ph = lgr_pkg::PH_FLUSH;
                    emit_run();
                end
            end
            lgr_pkg::MODE_CONT: begin
                if (run_pending())
                    emit_run();
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result side: ready pattern, hold-off and checking
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_grid_point want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (hold_seq != hold_seen) begin
                hold_seen <= hold_seq;
                hold_left <= HOLD_LEN;
                i_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_ready   <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end

            if (o_valid && i_ready) begin
                if (expected_points.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected point grid_x=%h value=%h", $time,
                             o_grid_x, o_value);
                end else begin
                    want = expected_points.pop_front();
                    if (o_grid_x !== want.grid_x) begin
                        n_errors++;
                        $display("%0t: grid_x expected %h actual %h", $time,
                                 want.grid_x, o_grid_x);
                    end
                    if (o_value !== want.value) begin
                        n_errors++;
                        $display("%0t: value at %h expected %h actual %h", $time,
                                 want.grid_x, want.value, o_value);
                    end
                    if (o_last !== want.last) begin
                        n_errors++;
                        $display("%0t: last at %h expected %b actual %b", $time,
                                 want.grid_x, want.last, o_last);
                    end
                    if (o_more !== want.more) begin
                        n_errors++;
                        $display("%0t: more at %h expected %b actual %b", $time,
                                 want.grid_x, want.more, o_more);
                    end
                    if (o_finished !== want.fin) begin
                        n_errors++;
                        $display("%0t: finished at %h expected %b actual %b", $time,
                                 want.grid_x, want.fin, o_finished);
                    end
                end
            end
        end
    end

    // watchdog: cycles without any handshake on any channel
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("log_grid_linear_resampler_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------

    // one request; valid is left high so a following request needs no gap
    task automatic send_item(logic [1:0] mode, logic [31:0] x, logic signed [31:0] y);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_gap_pct)
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= mode;
        i_sample_x <= x;
        i_sample_y <= y;
        do @(posedge i_clk); while (!o_ready);
        resample_predict(mode, x, y);
    endtask

    // sender pause until every owed point has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            lgr_pkg::CFG_START: begin
                g_start = data;
                if (ph == lgr_pkg::PH_AWAIT)
                    nxt_grid = data;
            end
            lgr_pkg::CFG_END:   g_end = data;
            lgr_pkg::CFG_RATIO: g_ratio = data;
            default: ;
        endcase
    endtask

    // well-formed traffic: continue a cut run, otherwise extend the curve
    task automatic good_item();
        int k;
        if (run_pending()) begin
            send_item(lgr_pkg::MODE_CONT, $urandom, $urandom);
        end else begin
            k = ($urandom_range(9) == 0) ? 1 : $urandom_range(3, 9);
            send_item(lgr_pkg::MODE_SAMPLE, nxt_grid + (nxt_grid >> k), $urandom);
        end
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (run_pending()) begin
            // requests other than continue are dropped while a run is cut
            if (pick < 85)
                good_item();
            else
                send_item(logic'(pick[0]) ? lgr_pkg::MODE_END : lgr_pkg::MODE_SAMPLE,
                          $urandom, $urandom);
        end else if (pick < 75) begin
            good_item();
        end else if (pick < 83) begin
            // x going backward: becomes the new lower end, no points
            send_item(lgr_pkg::MODE_SAMPLE, $urandom_range(lo_x), $urandom);
        end else if (pick < 88) begin
            send_item(lgr_pkg::MODE_SAMPLE, lo_x, $urandom);
        end else if (pick < 93) begin
            send_item(MODE_UNUSED, $urandom, $urandom);
        end else begin
            send_item(lgr_pkg::MODE_CONT, $urandom, $urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // start and end at their extremes, ratio at its maximum, while waiting for the first sample
    task automatic test_config_registers();
        write_reg(lgr_pkg::CFG_START, 32'h0000_0001);
        write_reg(lgr_pkg::CFG_START, 32'hFFFF_FFFF);
        write_reg(lgr_pkg::CFG_END, 32'h0000_0001);
        write_reg(lgr_pkg::CFG_END, 32'hFFFF_FFFF);
        write_reg(lgr_pkg::CFG_RATIO, RATIO_MAX);
        write_reg(lgr_pkg::CFG_RATIO, RATIO_FINE);
        write_reg(lgr_pkg::CFG_START, 32'h0001_0000);
    endtask

    // first sample on a grid point, zero width segment, long run cut at
    // MAX_RUN, ignored requests while pending, backward x
    task automatic test_directed_segments();
        send_item(lgr_pkg::MODE_SAMPLE, 32'h0001_0000, 32'h7FFF_FFFF);
        send_item(lgr_pkg::MODE_SAMPLE, 32'h0001_0000, 32'h8000_0000);
        send_item(lgr_pkg::MODE_SAMPLE, 32'h0002_0000, 32'h0000_0000);
        send_item(lgr_pkg::MODE_SAMPLE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_item(lgr_pkg::MODE_END, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        while (run_pending())
            send_item(lgr_pkg::MODE_CONT, 32'h0, 32'h0);
        send_item(lgr_pkg::MODE_CONT, 32'h0, 32'h0);
        send_item(lgr_pkg::MODE_SAMPLE, 32'h0000_0000, 32'h8000_0000);
        send_item(lgr_pkg::MODE_SAMPLE, nxt_grid + (nxt_grid >> 2), 32'h8000_0000);
        send_item(lgr_pkg::MODE_SAMPLE, nxt_grid + (nxt_grid >> 3), 32'h7FFF_FFFF);
        while (run_pending())
            send_item(lgr_pkg::MODE_CONT, 32'h0, 32'h0);
        wait_drained();
    endtask

    // smallest ratio leaves the grid stuck, so every run is cut
    task automatic test_min_ratio();
        write_reg(lgr_pkg::CFG_RATIO, RATIO_MIN);
        send_item(lgr_pkg::MODE_SAMPLE, nxt_grid << 1, $urandom);
        send_item(lgr_pkg::MODE_CONT, 32'h0, 32'h0);
        send_item(lgr_pkg::MODE_CONT, 32'h0, 32'h0);
        write_reg(lgr_pkg::CFG_RATIO, RATIO_FINE);
        while (run_pending())
            send_item(lgr_pkg::MODE_CONT, 32'h0, 32'h0);
        wait_drained();
    endtask

    task automatic test_random_phases();
        int gaps[4]   = '{0, 45, 0, 18};
        int stalls[4] = '{0, 0, 45, 18};
        for (int p = 0; p < 4; p++) begin
            send_gap_pct   = gaps[p];
            recv_stall_pct = stalls[p];
            for (int i = 0; i < PHASE_LEN; i++)
                random_item();
            wait_drained();
        end
    endtask

    // results back up while requests keep coming, so the input stalls
    task automatic test_receiver_holdoff();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_seq = hold_seq + 1;
        for (int i = 0; i < 10; i++)
            good_item();
        wait_drained();
    endtask

    // coarse ratio to reach the top of the range, then flush past the end
    task automatic test_climb_and_flush();
        send_gap_pct   = 18;
        recv_stall_pct = 18;
        write_reg(lgr_pkg::CFG_RATIO, RATIO_MAX);
        // grid_start is only reloaded before the first sample
        write_reg(lgr_pkg::CFG_START, 32'h0000_0001);
        // a cut run would swallow every sample below
        while (run_pending())
            send_item(lgr_pkg::MODE_CONT, 32'h0, 32'h0);
        while (nxt_grid < 32'h2000_0000)
            send_item(lgr_pkg::MODE_SAMPLE, nxt_grid + $urandom_range(nxt_grid), $urandom);
        send_item(lgr_pkg::MODE_SAMPLE, nxt_grid - $urandom_range(nxt_grid >> 1) - 1,
                  32'h8000_0000);
        send_item(lgr_pkg::MODE_END, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        while (run_pending())
            send_item(lgr_pkg::MODE_CONT, 32'h0, 32'h0);
        // finished: nothing answers any more
        send_item(lgr_pkg::MODE_SAMPLE, $urandom, $urandom);
        send_item(lgr_pkg::MODE_CONT, 32'h0, 32'h0);
        send_item(lgr_pkg::MODE_END, 32'h0, 32'h0);
        send_item(MODE_UNUSED, 32'h0, 32'h0);
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_config_registers();
        test_directed_segments();
        test_min_ratio();
        test_receiver_holdoff();
        test_random_phases();
        test_climb_and_flush();

        repeat (SETTLE) @(posedge i_clk);
        if (n_errors == 0 && expected_points.size() == 0) begin
            $display("log_grid_linear_resampler_unit regression: pass");
        end else begin
            $display("log_grid_linear_resampler_unit regression: fail");
        end
        $finish;
    end

endmodule
